// ===== hdl/utf8_decode_with_replacement_top_defines.svh =====
// Assertion macros for the UTF-8 decoder checker.
// Used by utf8d_chk only; needs clk and rst_n in the including scope.
`ifndef UTF8_DECODE_WITH_REPLACEMENT_TOP_DEFINES_SVH
`define UTF8_DECODE_WITH_REPLACEMENT_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define UTF8D_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define UTF8D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/utf8d_pkg.sv =====
// Shared types and constants of the UTF-8 decoder.
// No dependencies.
`default_nettype none
package utf8d_pkg;

  localparam int unsigned CP_W  = 21;
  localparam int unsigned CNT_W = 3;

  localparam logic [CP_W-1:0] REPL_CP       = 21'h00FFFD;
  localparam logic [CP_W-1:0] NON_ASCII_MIN = 21'h000080;
  localparam logic [CP_W-1:0] SYL_LO        = 21'h00AC00;
  localparam logic [CP_W-1:0] SYL_HI        = 21'h00D7A3;

  localparam logic [2:0] LEN_IDLE = 3'd0;
  localparam logic [2:0] LEN_TWO  = 3'd2;
  localparam logic [2:0] LEN_THR  = 3'd3;
  localparam logic [2:0] LEN_FOUR = 3'd4;

  // Results caused by one byte: cnt words, all U+FFFD except possibly the
  // last, which carries tail_cp and the updated flags.
  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [CP_W-1:0]  tail_cp;
    logic             old_mark;
    logic             old_syl;
    logic             new_mark;
    logic             new_syl;
    logic             eos;
  } burst_t;

endpackage
`default_nettype wire

// ===== hdl/utf8_decode_with_replacement_top.sv =====
// Top level of the UTF-8 decoder with replacement.
// Depends on utf8d_pkg, utf8d_decode and utf8d_emit.
//
//   channel  handshake         payload
//   in       in_valid/in_stall in_byte_in[7:0], in_end_of_string
//   out      out_valid/out_stall out_code_point[20:0], out_seen_non_ascii,
//                              out_seen_syllable, out_final_result
//
// One byte per cycle enters the input register while in_stall is low; decode runs
// between it and the result register. A byte causing n words holds the result
// register until its n words are taken; bytes with no word pass without it.
// From accept to first word, a byte passes the input and then the result register.
// Synchronous active-low reset clears the sequence state and running flags.
// out_stall reaches in_stall in the same cycle through the result register.
`default_nettype none
module utf8_decode_with_replacement_top (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [7:0]                in_byte_in,
  input  wire logic                      in_end_of_string,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [utf8d_pkg::CP_W-1:0]     out_code_point,
  output logic                           out_seen_non_ascii,
  output logic                           out_seen_syllable,
  output logic                           out_final_result
);
  import utf8d_pkg::*;

  logic       in_v_r;
  logic [7:0] byte_r;
  logic       eos_r;
  logic       adv;
  logic       free;
  burst_t     burst;

  assign adv      = in_v_r && ((burst.cnt == '0) || free);
  assign in_stall = in_v_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      byte_r <= in_byte_in;
      eos_r  <= in_end_of_string;
    end
  end

  utf8d_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (adv),
    .byte_in (byte_r),
    .eos     (eos_r),
    .burst   (burst)
  );

  utf8d_emit u_emit (
    .clk                (clk),
    .rst_n              (rst_n),
    .load               (adv && (burst.cnt != '0)),
    .burst              (burst),
    .free               (free),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_code_point     (out_code_point),
    .out_seen_non_ascii (out_seen_non_ascii),
    .out_seen_syllable  (out_seen_syllable),
    .out_final_result   (out_final_result)
  );

endmodule
`default_nettype wire

// ===== hdl/utf8d_decode.sv =====
// Sequence state and per-byte decode of the UTF-8 decoder.
// Depends on utf8d_pkg.
`default_nettype none
module utf8d_decode (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            step,
  input  wire logic [7:0]      byte_in,
  input  wire logic            eos,
  output utf8d_pkg::burst_t    burst
);
  import utf8d_pkg::*;

  logic [1:0]      held_r, held_nxt;
  logic [2:0]      exp_r, exp_nxt;
  logic [CP_W-1:0] part_r, part_nxt;
  logic            mark_r, mark_nxt;
  logic            syl_r, syl_nxt;

  logic            trail;
  logic [CP_W-1:0] shifted;
  logic [CNT_W-1:0] rep;
  logic [CNT_W-1:0] cnt;
  logic [CP_W-1:0] tail_cp;
  logic            tail_dec;
  logic            new_mark, new_syl;

  assign trail   = (byte_in[7:6] == 2'b10);
  assign shifted = {part_r[CP_W-7:0], byte_in[5:0]};

  always_comb begin
    held_nxt = held_r;
    exp_nxt  = exp_r;
    part_nxt = part_r;
    cnt      = '0;
    tail_cp  = REPL_CP;
    tail_dec = 1'b0;
    rep      = '0;
    if (exp_r != LEN_IDLE && trail) begin
      if (({1'b0, held_r} + 3'd1) >= exp_r) begin
        cnt      = 3'd1;
        tail_cp  = shifted;
        tail_dec = 1'b1;
        held_nxt = '0;
        exp_nxt  = LEN_IDLE;
        part_nxt = '0;
      end else if (eos) begin
        cnt      = {1'b0, held_r} + 3'd1;
        held_nxt = '0;
        exp_nxt  = LEN_IDLE;
        part_nxt = '0;
      end else begin
        held_nxt = held_r + 2'd1;
        part_nxt = shifted;
      end
    end else begin
      if (exp_r != LEN_IDLE) begin
        rep = {1'b0, held_r};
      end
      held_nxt = '0;
      exp_nxt  = LEN_IDLE;
      part_nxt = '0;
      case (byte_in) inside
        8'b0???_????: begin
          cnt      = rep + 3'd1;
          tail_cp  = {13'd0, byte_in};
          tail_dec = 1'b1;
        end
        8'b110?_????, 8'b1110_????, 8'b1111_0???: begin
          if (eos) begin
            cnt = rep + 3'd1;
          end else begin
            cnt      = rep;
            held_nxt = 2'd1;
            if (byte_in[7:5] == 3'b110) begin
              exp_nxt  = LEN_TWO;
              part_nxt = {16'd0, byte_in[4:0]};
            end else if (byte_in[7:4] == 4'b1110) begin
              exp_nxt  = LEN_THR;
              part_nxt = {17'd0, byte_in[3:0]};
            end else begin
              exp_nxt  = LEN_FOUR;
              part_nxt = {18'd0, byte_in[2:0]};
            end
          end
        end
        default: begin
          cnt = rep + 3'd1;
        end
      endcase
    end
    if (eos) begin
      held_nxt = '0;
      exp_nxt  = LEN_IDLE;
      part_nxt = '0;
    end
  end

  assign new_mark = mark_r | (tail_dec && tail_cp >= NON_ASCII_MIN);
  assign new_syl  = syl_r | (tail_dec && tail_cp >= SYL_LO && tail_cp <= SYL_HI);
  assign mark_nxt = eos ? 1'b0 : new_mark;
  assign syl_nxt  = eos ? 1'b0 : new_syl;

  always_comb begin
    burst.cnt      = cnt;
    burst.tail_cp  = tail_cp;
    burst.old_mark = mark_r;
    burst.old_syl  = syl_r;
    burst.new_mark = new_mark;
    burst.new_syl  = new_syl;
    burst.eos      = eos;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      exp_r  <= LEN_IDLE;
      part_r <= '0;
      mark_r <= 1'b0;
      syl_r  <= 1'b0;
    end else if (step) begin
      held_r <= held_nxt;
      exp_r  <= exp_nxt;
      part_r <= part_nxt;
      mark_r <= mark_nxt;
      syl_r  <= syl_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/utf8d_emit.sv =====
// Result register of the UTF-8 decoder: holds one burst, sends its words in order.
// Depends on utf8d_pkg.
`default_nettype none
module utf8d_emit (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      load,
  input  utf8d_pkg::burst_t              burst,
  output logic                           free,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [utf8d_pkg::CP_W-1:0]     out_code_point,
  output logic                           out_seen_non_ascii,
  output logic                           out_seen_syllable,
  output logic                           out_final_result
);
  import utf8d_pkg::*;

  logic       bv_r;
  logic [1:0] idx_r;
  burst_t     bst_r;
  logic       last;
  logic       take;

  assign last = ({1'b0, idx_r} == (bst_r.cnt - 3'd1));
  assign take = bv_r && !out_stall;
  assign free = !bv_r || (take && last);

  assign out_valid          = bv_r;
  assign out_code_point     = last ? bst_r.tail_cp : REPL_CP;
  assign out_seen_non_ascii = last ? bst_r.new_mark : bst_r.old_mark;
  assign out_seen_syllable  = last ? bst_r.new_syl : bst_r.old_syl;
  assign out_final_result   = last && bst_r.eos;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r  <= 1'b0;
      idx_r <= '0;
    end else if (load) begin
      bv_r  <= 1'b1;
      idx_r <= '0;
    end else if (take) begin
      if (last) begin
        bv_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bst_r <= burst;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/utf8d_chk.sv =====
// Port-level checker for the UTF-8 decoder, bound to the top level.
// Depends on utf8_decode_with_replacement_top_defines.svh.
`default_nettype none
`include "utf8_decode_with_replacement_top_defines.svh"
module utf8d_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [7:0]  in_byte_in,
  input wire logic        in_end_of_string,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [20:0] out_code_point,
  input wire logic        out_seen_non_ascii,
  input wire logic        out_seen_syllable,
  input wire logic        out_final_result
);

  `UTF8D_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_byte_in) && $stable(in_end_of_string), "stalled input word changed")
  `UTF8D_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_code_point) && $stable(out_final_result), "stalled output word changed")
  `UTF8D_ASSERT_NOW(a_syl_mark, out_valid && out_seen_syllable, out_seen_non_ascii, "syllable flag without non-ASCII flag")
  `UTF8D_ASSERT_NOW(a_mark_set, out_valid && out_code_point >= 21'h80 && out_code_point != 21'hFFFD, out_seen_non_ascii, "non-ASCII word without flag")
  `UTF8D_ASSERT_NOW(a_syl_set, out_valid && out_code_point >= 21'hAC00 && out_code_point <= 21'hD7A3, out_seen_syllable, "syllable word without flag")

endmodule

bind utf8_decode_with_replacement_top utf8d_chk u_chk (.*);
`default_nettype wire
